[rtl/tgt_pkg.sv]
// ----------------------------------------------------------------------------
// tgt_pkg: shared definitions for the tone generator timer
// Request codes, prescaler tables, arithmetic sizes and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tgt_pkg;

   // Request kinds carried on the request channel's tuser.
   localparam logic [1:0] REQ_PLAY = 2'd0;
   localparam logic [1:0] REQ_STOP = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   localparam int CLOCK_HZ_DEFAULT = 16000000;

   localparam int FREQ_W     = 16;
   localparam int DURATION_W = 32;
   localparam int TOGGLE_W   = 32;
   localparam int MATCH_W    = 8;
   localparam int CODE_W     = 3;
   localparam int PRESC_W    = 10;

   // Width of frequency times duration, also used as the serial divider's
   // dividend width.
   localparam int DIV_NUM_W = FREQ_W + DURATION_W;
   localparam int DIV_DEN_W = FREQ_W;

   // 2 * f * ms / 1000 equals f * ms / 500.
   localparam int COUNT_DIVISOR = 500;
   // Smallest product whose toggle count exceeds the 31-bit limit: 500 * 2^31.
   localparam logic [DIV_NUM_W-1:0] SAT_PRODUCT = 48'd1073741824000;

   // floor(z / 125) equals (z * RECIP_125) >> RECIP_SHIFT for every z below
   // 2^30; dividing by 500 is a shift by two followed by this step.
   localparam int          RECIP_SHIFT = 37;
   localparam logic [30:0] RECIP_125   = 31'd1099511628;

   localparam logic [TOGGLE_W-1:0] TOGGLE_MAX     = 32'h7FFF_FFFF;
   localparam logic [TOGGLE_W-1:0] TOGGLE_FOREVER = 32'hFFFF_FFFF;

   localparam logic [CODE_W-1:0] CODE_DIV1    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_DIV1024 = 3'd7;

   // Clock divisor for a prescaler code; the unused code divides by one.
   function automatic logic [PRESC_W:0] prescale_div(input logic [CODE_W-1:0] code);
      logic [PRESC_W:0] d;
      case (code)
         3'd2:    d = 11'd8;
         3'd3:    d = 11'd32;
         3'd4:    d = 11'd64;
         3'd5:    d = 11'd128;
         3'd6:    d = 11'd256;
         3'd7:    d = 11'd1024;
         default: d = 11'd1;
      endcase
      return d;
   endfunction

   // The same divisor expressed as a right-shift amount.
   function automatic logic [3:0] prescale_shift(input logic [CODE_W-1:0] code);
      logic [3:0] s;
      case (code)
         3'd2:    s = 4'd3;
         3'd3:    s = 4'd5;
         3'd4:    s = 4'd6;
         3'd5:    s = 4'd7;
         3'd6:    s = 4'd8;
         3'd7:    s = 4'd10;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_HALF      = 4'b0010,
      ST_HALF_WAIT = 4'b0100,
      ST_LOAD      = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic half_latch;
      logic load_play;
   } dp_cmd_type;

   typedef struct packed {
      logic is_long;
      logic div_done;
   } dp_status_type;

endpackage

[rtl/tgt_divider.sv]
// ----------------------------------------------------------------------------
// tgt_divider: serial restoring divider
// Produces one quotient bit per clock; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module tgt_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tgt_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [tgt_pkg::DIV_DEN_W-1:0]  divisor,
   output logic [tgt_pkg::DIV_NUM_W-1:0]  quotient,
   output logic                           done
);
   import tgt_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W:0]   rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so its low bits suffice.
         rem_in = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = num_ff;
   assign done     = done_ff;

endmodule

[rtl/tgt_datapath.sv]
// ----------------------------------------------------------------------------
// tgt_datapath: tone timer state, tick logic and play setup arithmetic
// Holds the timer state, advances it on ticks, finds the divisor and match
// value of a play request with the serial divider, and derives the toggle
// count with a short reciprocal-multiply pipeline.
// ----------------------------------------------------------------------------
module tgt_datapath #(
   parameter int CLOCK_HZ = tgt_pkg::CLOCK_HZ_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tgt_pkg::dp_cmd_type             cmd,
   output tgt_pkg::dp_status_type          status,
   input  logic [1:0]                      req_type,
   input  logic [tgt_pkg::FREQ_W-1:0]      req_freq,
   input  logic [tgt_pkg::DURATION_W-1:0]  req_ms,
   output logic                            pin_level,
   output logic                            playing,
   output logic [tgt_pkg::MATCH_W-1:0]     compare_value,
   output logic [tgt_pkg::CODE_W-1:0]      prescale_code
);
   import tgt_pkg::*;

   localparam int HALF_W = $clog2(CLOCK_HZ + 1);

   logic                  playing_ff, playing_in;
   logic                  pin_ff, pin_in;
   logic [TOGGLE_W-1:0]   toggles_ff, toggles_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [MATCH_W-1:0]    match_ff, match_in;
   logic [PRESC_W-1:0]    presc_ff, presc_in;
   logic [MATCH_W-1:0]    tick_ff, tick_in;

   logic [FREQ_W-1:0]     freq_ff;
   logic [DURATION_W-1:0] ms_ff;
   logic [DIV_NUM_W-1:0]  prod_ff;
   logic [HALF_W-1:0]     half_ff;

   // Toggle count pipeline: f * ms / 500 = f * q + f * r / 500 with
   // ms = 500 * q + r.
   logic [23:0]           qm_ff, qm_in;
   logic [8:0]            rm_ff, rm_in;
   logic [39:0]           part_hi_ff, part_hi_in;
   logic [24:0]           part_lo_ff, part_lo_in;
   logic [15:0]           q_lo_ff, q_lo_in;
   logic [60:0]           qm_prod;
   logic [53:0]           q_lo_prod;
   logic [31:0]           rm_full;
   logic [39:0]           count_sum;

   logic [DIV_NUM_W-1:0]  prod_in;
   logic [DIV_NUM_W-1:0]  div_num;
   logic [DIV_NUM_W-1:0]  quotient;
   logic                  div_done;

   logic [PRESC_W:0]      presc_inc;
   logic [CODE_W-1:0]     new_code;
   logic [MATCH_W-1:0]    new_match;
   logic [TOGGLE_W-1:0]   new_toggles;

   assign prod_in = DIV_NUM_W'(req_freq) * DIV_NUM_W'(req_ms);

   assign div_num = DIV_NUM_W'(CLOCK_HZ);

   tgt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (freq_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.is_long  = (req_type == REQ_PLAY) && (req_freq != '0);
   assign status.div_done = div_done;

   // The pipeline runs freely on the latched request; its registers settle long
   // before the half-period division ends.
   assign qm_prod    = 61'(ms_ff[DURATION_W-1:2]) * 61'(RECIP_125);
   assign qm_in      = qm_prod[RECIP_SHIFT +: 24];
   assign rm_full    = ms_ff - 32'(qm_ff) * 32'(COUNT_DIVISOR);
   assign rm_in      = rm_full[8:0];
   assign part_hi_in = 40'(freq_ff) * 40'(qm_ff);
   assign part_lo_in = 25'(freq_ff) * 25'(rm_ff);
   assign q_lo_prod  = 54'(part_lo_ff[24:2]) * 54'(RECIP_125);
   assign q_lo_in    = q_lo_prod[RECIP_SHIFT +: 16];
   assign count_sum  = part_hi_ff + 40'(q_lo_ff);

   // Divisor search: the smallest code whose shifted half period is 1..256, else the divide-by-1024 code.
   always_comb begin
      logic [HALF_W-1:0] s;
      logic [HALF_W-1:0] s_m1;
      s         = half_ff >> prescale_shift(CODE_DIV1024);
      s_m1      = s - HALF_W'(1);
      new_code  = CODE_DIV1024;
      new_match = s_m1[MATCH_W-1:0];
      for (int i = 6; i >= 1; i--) begin
         s    = half_ff >> prescale_shift(CODE_W'(i));
         s_m1 = s - HALF_W'(1);
         if ((s != '0) && (s <= HALF_W'(256))) begin
            new_code  = CODE_W'(i);
            new_match = s_m1[MATCH_W-1:0];
         end
      end
   end

   always_comb begin
      if (ms_ff == '0) begin
         new_toggles = TOGGLE_FOREVER;
      end else if (prod_ff >= SAT_PRODUCT) begin
         new_toggles = TOGGLE_MAX;
      end else begin
         new_toggles = count_sum[TOGGLE_W-1:0];
      end
   end

   assign presc_inc = {1'b0, presc_ff} + (PRESC_W+1)'(1);

   always_comb begin
      playing_in = playing_ff;
      pin_in     = pin_ff;
      toggles_in = toggles_ff;
      code_in    = code_ff;
      match_in   = match_ff;
      presc_in   = presc_ff;
      tick_in    = tick_ff;
      if (cmd.accept) begin
         case (req_type)
            REQ_PLAY: begin
               if (req_freq == '0) begin
                  playing_in = 1'b0;
                  pin_in     = 1'b0;
               end
            end
            REQ_STOP: begin
               playing_in = 1'b0;
               pin_in     = 1'b0;
            end
            REQ_TICK: begin
               if (playing_ff) begin
                  if (presc_inc >= prescale_div(code_ff)) begin
                     presc_in = '0;
                     if (tick_ff == match_ff) begin
                        tick_in = '0;
                        if (toggles_ff != '0) begin
                           pin_in = ~pin_ff;
                           if (toggles_ff != TOGGLE_FOREVER) begin
                              toggles_in = toggles_ff - TOGGLE_W'(1);
                           end
                        end else begin
                           playing_in = 1'b0;
                           pin_in     = 1'b0;
                        end
                     end else begin
                        tick_in = tick_ff + MATCH_W'(1);
                     end
                  end else begin
                     presc_in = presc_inc[PRESC_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.load_play) begin
         code_in    = new_code;
         match_in   = new_match;
         toggles_in = new_toggles;
         presc_in   = '0;
         tick_in    = '0;
         playing_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         pin_ff     <= 1'b0;
         toggles_ff <= '0;
         code_ff    <= CODE_DIV1;
         match_ff   <= '0;
         presc_ff   <= '0;
         tick_ff    <= '0;
      end else begin
         playing_ff <= playing_in;
         pin_ff     <= pin_in;
         toggles_ff <= toggles_in;
         code_ff    <= code_in;
         match_ff   <= match_in;
         presc_ff   <= presc_in;
         tick_ff    <= tick_in;
      end
      if (cmd.accept && status.is_long) begin
         freq_ff <= req_freq;
         ms_ff   <= req_ms;
         prod_ff <= prod_in;
      end
      if (cmd.half_latch) begin
         half_ff <= quotient[HALF_W:1];
      end
      qm_ff      <= qm_in;
      rm_ff      <= rm_in;
      part_hi_ff <= part_hi_in;
      part_lo_ff <= part_lo_in;
      q_lo_ff    <= q_lo_in;
   end

   assign pin_level     = pin_ff;
   assign playing       = playing_ff;
   assign compare_value = match_ff;
   assign prescale_code = code_ff;

endmodule

[rtl/tgt_ctrl.sv]
// ----------------------------------------------------------------------------
// tgt_ctrl: request sequencer and result handshake
// Accepts requests, steps a play request through its half-period division
// and keeps the result channel's valid flag.
// ----------------------------------------------------------------------------
module tgt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tgt_pkg::dp_status_type status,
   output tgt_pkg::dp_cmd_type    cmd
);
   import tgt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = accept;
      cmd.div_start  = 1'b0;
      cmd.half_latch = 1'b0;
      cmd.load_play  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status.is_long) begin
               state_in = ST_HALF;
            end
         end
         ST_HALF: begin
            cmd.div_start = 1'b1;
            state_in      = ST_HALF_WAIT;
         end
         ST_HALF_WAIT: begin
            if (status.div_done) begin
               cmd.half_latch = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               cmd.load_play = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((accept && !status.is_long) || cmd.load_play) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/tone_generator_timer.sv]
// ----------------------------------------------------------------------------
// tone_generator_timer: square-wave tone generator on an 8-bit compare timer
// A play request picks a clock divisor and match value from the frequency
// and loads a toggle count from the duration; tick requests advance the
// prescaler and timer, toggling the pin at each compare match.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata (low bit up)                    tuser
//  -------  ---------  ------------------------------------  -----------------
//  req_     in         frequency_hz[15:0], duration_ms[47:16] req_type[1:0]
//  rsp_     out        pin_level[0], playing[1],              none
//                      compare_value[9:2], prescale_code[12:10]
//
//  Tick, stop, unused and zero-frequency play requests complete without leaving
//  the idle state, so ticks stream at one per clock while results are taken.
//  A play request with a nonzero frequency holds the request channel closed
//  until it presents its result, through the HALF, HALF_WAIT and LOAD states;
//  the time is set by the 48-step serial divider that finds CLOCK_HZ / frequency.
//  The toggle count comes from a multiply pipeline that is ready well before.
//  Reset is synchronous and active high and returns the timer to idle.
//  A result that is not taken stalls the request channel after one transfer;
//  the result is shown directly from the timer state registers.
//
module tone_generator_timer #(
   parameter int CLOCK_HZ = tgt_pkg::CLOCK_HZ_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // frequency_hz[15:0], duration_ms[47:16]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // pin_level[0], playing[1],
                                    // compare_value[9:2], prescale_code[12:10]
);
   import tgt_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic                pin_level;
   logic                playing;
   logic [MATCH_W-1:0]  compare_value;
   logic [CODE_W-1:0]   prescale_code;

   // The controller sequences requests; it never touches payload directly.
   tgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds all timer state and the setup arithmetic.
   tgt_datapath #(
      .CLOCK_HZ (CLOCK_HZ)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_tuser),
      .req_freq      (req_tdata[15:0]),
      .req_ms        (req_tdata[47:16]),
      .pin_level     (pin_level),
      .playing       (playing),
      .compare_value (compare_value),
      .prescale_code (prescale_code)
   );

   // Pack the result fields from the low bit up; the top bits are padding.
   assign rsp_tdata = {3'b000, prescale_code, compare_value, playing, pin_level};

endmodule

[tb/tone_generator_timer_tb.sv]
// ----------------------------------------------------------------------------
// tone_generator_timer_tb: self-checking bench for the tone generator timer
// Drives play, stop, tick and unused requests through the request stream,
// predicts the status word that each request returns, and checks every
// transfer on the result stream against it.
// ----------------------------------------------------------------------------
module tone_generator_timer_tb;
   import tgt_pkg::*;

   // The fourth request code is not assigned a meaning by the block.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RUN_LIMIT = 1000000;
   localparam int END_SETTLE = 200;

   // Status word that the block reports after each request.
   typedef struct packed {
      logic       pin;
      logic       playing;
      logic [7:0] compare;
      logic [2:0] code;
   } tone_status_type;

   // The tracker keeps its own copy of the timer state, works out the status
   // word for every accepted request and compares it with what the block
   // returns, oldest first.
   class tone_tracker;
      bit              playing_q;
      bit              pin_q;
      bit [31:0]       toggles_left;
      bit [2:0]        div_code;
      bit [7:0]        match_q;
      bit [9:0]        presc_cnt;
      bit [7:0]        timer_cnt;
      tone_status_type expected_status[$];
      int              mismatches;

      function new();
         playing_q    = 1'b0;
         pin_q        = 1'b0;
         toggles_left = '0;
         div_code     = CODE_DIV1;
         match_q      = '0;
         presc_cnt    = '0;
         timer_cnt    = '0;
         mismatches   = 0;
      endfunction

      function int unsigned clock_divisor(bit [2:0] code);
         case (code)
            3'd2:    return 8;
            3'd3:    return 32;
            3'd4:    return 64;
            3'd5:    return 128;
            3'd6:    return 256;
            3'd7:    return 1024;
            default: return 1;
         endcase
      endfunction

      function void end_tone();
         playing_q = 1'b0;
         pin_q     = 1'b0;
      endfunction

      // A compare match toggles the pin while toggles remain; a match with
      // the count exhausted ends the tone.
      function void compare_match();
         if (toggles_left != 32'd0) begin
            pin_q = ~pin_q;
            if (toggles_left != TOGGLE_FOREVER)
               toggles_left = toggles_left - 32'd1;
         end else begin
            end_tone();
         end
      endfunction

      function void advance_clock();
         if (!playing_q)
            return;
         if (int'(presc_cnt) + 1 >= int'(clock_divisor(div_code))) begin
            presc_cnt = '0;
            if (timer_cnt == match_q) begin
               timer_cnt = '0;
               compare_match();
            end else begin
               timer_cnt = timer_cnt + 8'd1;
            end
         end else begin
            presc_cnt = presc_cnt + 10'd1;
         end
      endfunction

      function void start_tone(bit [15:0] freq, bit [31:0] ms);
         int unsigned       half;
         int unsigned       ocr;
         longint unsigned   f64;
         longint unsigned   ms64;
         longint unsigned   count;
         bit                found;
         half  = int'(CLOCK_HZ_DEFAULT) / int'(freq) / 2;
         found = 1'b0;
         ocr   = 0;
         // Smallest divisor whose match value fits in eight bits; a zero
         // quotient wraps and so never fits.
         for (int c = 1; c <= 6; c++) begin
            if (!found) begin
               ocr = half / clock_divisor(c[2:0]) - 32'd1;
               if (ocr <= 32'd255) begin
                  found    = 1'b1;
                  div_code = c[2:0];
               end
            end
         end
         if (!found) begin
            div_code = CODE_DIV1024;
            ocr      = (half / 32'd1024 - 32'd1) & 32'hFF;
         end
         match_q = ocr[7:0];
         if (ms != 32'd0) begin
            f64   = 64'(freq);
            ms64  = 64'(ms);
            count = 2 * f64 * ms64 / 1000;
            if (count > 64'h7FFF_FFFF)
               count = 64'h7FFF_FFFF;
            toggles_left = count[31:0];
         end else begin
            toggles_left = TOGGLE_FOREVER;
         end
         presc_cnt = '0;
         timer_cnt = '0;
         playing_q = 1'b1;
      endfunction

      function void note_request(logic [1:0] kind, logic [15:0] freq, logic [31:0] ms);
         tone_status_type s;
         case (kind)
            REQ_PLAY: begin
               if (freq == 16'd0)
                  end_tone();
               else
                  start_tone(freq, ms);
            end
            REQ_STOP: end_tone();
            REQ_TICK: advance_clock();
            default: ;
         endcase
         s.pin     = pin_q;
         s.playing = playing_q;
         s.compare = match_q;
         s.code    = div_code;
         expected_status.push_back(s);
      endfunction

      function void check_status(logic [15:0] word);
         tone_status_type want;
         tone_status_type got;
         got.pin     = word[0];
         got.playing = word[1];
         got.compare = word[9:2];
         got.code    = word[12:10];
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: tdata %h", word);
            return;
         end
         want = expected_status.pop_front();
         if (got.pin !== want.pin || got.playing !== want.playing ||
             got.compare !== want.compare || got.code !== want.code) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"status mismatch: expected pin %0d play %0d cmp %0d code %0d,",
                         " got pin %0d play %0d cmp %0d code %0d"},
                        want.pin, want.playing, want.compare, want.code,
                        got.pin, got.playing, got.compare, got.code);
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // frequency_hz[15:0], duration_ms[47:16]
   logic [1:0]  req_tuser = REQ_TICK;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // pin_level[0], playing[1],
                                  // compare_value[9:2], prescale_code[12:10]

   tone_tracker tracker;
   bit          idle_enable = 1'b0;
   bit          stall_enable = 1'b0;
   int          stall_left = 0;

   tone_generator_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: ready is dropped in random bursts while stalling is enabled,
   // and held high otherwise.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every result transfer is checked against the oldest prediction. The
   // values read here are those from before this edge's updates.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_status(rsp_tdata);
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // Presents one request and holds it until the transfer happens. Valid is
   // left high so that a following request continues without a gap.
   task automatic send_req(input logic [1:0] kind, input logic [15:0] freq,
                           input logic [31:0] ms);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {ms, freq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(kind, freq, ms);
   endtask

   task automatic sender_gap();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Holds the request side off until every prediction has been matched.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Play request mostly in the fast single-divisor range, so that compare
   // matches come within a few hundred ticks, with the rest of the range,
   // very low and zero frequencies mixed in.
   task automatic send_random_play();
      logic [15:0] freq;
      logic [31:0] ms;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: freq = 16'($urandom_range(31250, 65535));
         6:                freq = 16'($urandom_range(3892, 31249));
         7:                freq = 16'($urandom);
         8:                freq = 16'($urandom_range(1, 300));
         default:          freq = 16'd0;
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: ms = 32'd0;
         3, 4, 5: ms = $urandom_range(1, 3);
         6, 7:    ms = $urandom;
         default: ms = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
      endcase
      send_req(REQ_PLAY, freq, ms);
   endtask

   initial begin
      int ticks;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reset state, unused and stop requests, zero
      // frequency, saturated and zero toggle counts, a truncated match
      // value, one frequency for each divisor, and restart while playing.
      send_req(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF);
      send_req(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      send_req(REQ_STOP, 16'd0, 32'd0);
      send_req(REQ_PLAY, 16'd0, 32'd123);
      send_req(REQ_PLAY, 16'hFFFF, 32'hFFFF_FFFF);
      send_req(REQ_TICK, 16'd0, 32'd0);
      send_req(REQ_STOP, 16'd0, 32'd0);
      send_req(REQ_PLAY, 16'd1, 32'd0);
      send_req(REQ_PLAY, 16'd30, 32'd1);
      send_req(REQ_PLAY, 16'd31, 32'd5);
      send_req(REQ_PLAY, 16'd31250, 32'd0);
      send_req(REQ_PLAY, 16'd4000, 32'd2);
      send_req(REQ_PLAY, 16'd1000, 32'd10);
      send_req(REQ_PLAY, 16'd500, 32'd1);
      send_req(REQ_PLAY, 16'd250, 32'd7);
      send_req(REQ_PLAY, 16'd125, 32'd100);
      send_req(REQ_PLAY, 16'd62, 32'd0);
      send_req(REQ_PLAY, 16'd1, 32'd1);
      send_req(REQ_TICK, 16'd0, 32'd0);
      send_req(REQ_UNUSED, 16'd0, 32'd0);
      send_req(REQ_STOP, 16'hFFFF, 32'hFFFF_FFFF);
      send_req(REQ_TICK, 16'd0, 32'd0);

      // Random part: each sequence is a play request followed by a run of
      // ticks, now and then broken by a stop, an unused request or another
      // play. Idling on both sides is switched per sequence.
      for (int seq = 0; seq < 6; seq++) begin
         idle_enable  = ($urandom_range(0, 3) != 0);
         stall_enable = ($urandom_range(0, 3) != 0);
         sender_gap();
         send_random_play();
         if ($urandom_range(0, 9) < 7)
            ticks = $urandom_range(0, 30);
         else
            ticks = $urandom_range(130, 260);
         for (int i = 0; i < ticks; i++) begin
            sender_gap();
            if ($urandom_range(0, 19) == 0) begin
               case ($urandom_range(0, 2))
                  0:       send_req(REQ_STOP, 16'($urandom), $urandom);
                  1:       send_req(REQ_UNUSED, 16'($urandom), $urandom);
                  default: send_req(REQ_PLAY, 16'($urandom), $urandom);
               endcase
            end else begin
               send_req(REQ_TICK, 16'($urandom), $urandom);
            end
         end
         if (seq == 2)
            drain_results();
      end

      // Final part without idling: a fast tone with a short count and a
      // stream of back-to-back ticks that crosses compare matches.
      idle_enable  = 1'b0;
      stall_enable = 1'b0;
      send_req(REQ_PLAY, 16'($urandom_range(60000, 65535)), $urandom_range(1, 3));
      repeat (200) send_req(REQ_TICK, 16'($urandom), $urandom);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
